FILE: design/jsf_pkg.sv
package jsf_pkg;

  // Nesting depth counter width, default
  localparam int DepthBitsDef = 8;

  // Reset value of the segment length limit
  localparam logic [15:0] LengthLimitRst = 16'd4095;
  localparam logic [15:0] CountMax       = 16'hFFFF;

  // Bracket and string delimiters
  localparam logic [7:0] ChOpenCurly   = 8'h7B;
  localparam logic [7:0] ChOpenSquare  = 8'h5B;
  localparam logic [7:0] ChCloseCurly  = 8'h7D;
  localparam logic [7:0] ChCloseSquare = 8'h5D;
  localparam logic [7:0] ChQuote       = 8'h22;
  localparam logic [7:0] ChBackslash   = 8'h5C;

  // Queue between parser and framer
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  // One classified word handed from the parser to the framer
  typedef struct packed {
    logic [7:0] data;
    logic       is_start;
    logic       is_end;
  } item_t;

endpackage

FILE: design/json_segment_framer_unit.sv
// JSON segment framer.
// Input channel (in_valid/in_ready/in_data_byte): one byte of a JSON text stream
// per word. Result channel (out_valid/out_ready/out_*): one tagged word per input
// word, same order: the byte itself, start/end marks of a top-level object or
// array, keep (byte belongs to the stored segment), overflow flag and the kept
// byte count. Config channel (cfg_valid/cfg_ready/cfg_length_limit): writes the
// segment length limit; always ready, write only while the block is idle.
// Path: the parser is combinational and writes each accepted word into the queue;
// the framer pops it into the result register once that register is empty or its
// word is taken.
// Throughput: one word per cycle while out_ready stays high, set by the parse
// state update in the front and the count/lock update in the back.
// Reset (synchronous, rst_n low): parse state, count and lock cleared, limit set
// to 4095, queue and output register emptied.
// Receiver stall: the output register holds its word, the two-entry queue takes
// up to two more words, then in_ready drops until the receiver resumes.
module json_segment_framer_unit #(
  parameter int DEPTH_BITS = jsf_pkg::DepthBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_length_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic        out_is_start,
  output logic        out_is_end,
  output logic        out_keep,
  output logic        out_overflowed,
  output logic [15:0] out_segment_length
);

  jsf_pkg::item_t push_item, pop_item;
  logic           push, pop, q_full, q_empty;

  // front: classify each byte against the bracket and string state
  jsf_parser #(.DEPTH_BITS(DEPTH_BITS)) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (push),
    .q_item       (push_item)
  );

  // decouple front and back so either side can stall alone
  jsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  // back: count kept bytes, hold the overflow lock, drive the result register
  jsf_framer u_framer (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_length_limit   (cfg_length_limit),
    .q_empty            (q_empty),
    .q_item             (pop_item),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte_out       (out_byte_out),
    .out_is_start       (out_is_start),
    .out_is_end         (out_is_end),
    .out_keep           (out_keep),
    .out_overflowed     (out_overflowed),
    .out_segment_length (out_segment_length)
  );

endmodule

FILE: design/jsf_parser.sv
module jsf_parser #(
  parameter int DEPTH_BITS = jsf_pkg::DepthBitsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          q_full,
  output logic          q_push,
  output jsf_pkg::item_t q_item
);

  localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DepthZero = '0;
  localparam logic [DEPTH_BITS-1:0] DepthOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  logic [7:0]            prev_r;
  logic                  in_str_r, in_str_nxt;
  logic [DEPTH_BITS-1:0] curly_r, curly_nxt;
  logic [DEPTH_BITS-1:0] square_r, square_nxt;
  logic                  tag_start, tag_end;

  logic is_open, is_close, underflow;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    in_str_nxt = in_str_r;
    curly_nxt  = curly_r;
    square_nxt = square_r;
    tag_start  = 1'b0;
    tag_end    = 1'b0;
    underflow  = 1'b0;
    is_open    = (in_data_byte == jsf_pkg::ChOpenCurly) ||
                 (in_data_byte == jsf_pkg::ChOpenSquare);
    is_close   = (in_data_byte == jsf_pkg::ChCloseCurly) ||
                 (in_data_byte == jsf_pkg::ChCloseSquare);

    if (in_data_byte == jsf_pkg::ChQuote && prev_r != jsf_pkg::ChBackslash) begin
      in_str_nxt = !in_str_nxt;
    end
    // back-to-back top-level segments resynchronize the parser
    if ((in_data_byte == jsf_pkg::ChOpenCurly && prev_r == jsf_pkg::ChCloseCurly) ||
        (in_data_byte == jsf_pkg::ChOpenSquare && prev_r == jsf_pkg::ChCloseSquare)) begin
      in_str_nxt = 1'b0;
      curly_nxt  = DepthZero;
      square_nxt = DepthZero;
    end

    if (!in_str_nxt) begin
      tag_start = is_open && curly_nxt == DepthZero && square_nxt == DepthZero;
      if (in_data_byte == jsf_pkg::ChOpenCurly) begin
        if (curly_nxt != DepthMax) curly_nxt = curly_nxt + DepthOne;
      end else if (in_data_byte == jsf_pkg::ChOpenSquare) begin
        if (square_nxt != DepthMax) square_nxt = square_nxt + DepthOne;
      end else if (in_data_byte == jsf_pkg::ChCloseCurly) begin
        if (curly_nxt == DepthZero) underflow = 1'b1;
        else curly_nxt = curly_nxt - DepthOne;
      end else if (in_data_byte == jsf_pkg::ChCloseSquare) begin
        if (square_nxt == DepthZero) underflow = 1'b1;
        else square_nxt = square_nxt - DepthOne;
      end

      if (underflow) begin
        // drop all parse state on a stray closer
        curly_nxt  = DepthZero;
        square_nxt = DepthZero;
        tag_start  = 1'b0;
      end else if (is_close && curly_nxt == DepthZero && square_nxt == DepthZero) begin
        tag_end = 1'b1;
      end
    end
  end

  assign q_item.data     = in_data_byte;
  assign q_item.is_start = tag_start;
  assign q_item.is_end   = tag_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 8'h00;
      in_str_r <= 1'b0;
      curly_r  <= DepthZero;
      square_r <= DepthZero;
    end else if (q_push) begin
      prev_r   <= in_data_byte;
      in_str_r <= in_str_nxt;
      curly_r  <= curly_nxt;
      square_r <= square_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !(q_item.is_start && q_item.is_end))
    else $error("parser tagged a word as both start and end");
`endif

endmodule

FILE: design/jsf_queue.sv
module jsf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jsf_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output jsf_pkg::item_t pop_item
);

  localparam logic [jsf_pkg::QueueCntW-1:0] CntFull = jsf_pkg::QueueCntW'(jsf_pkg::QueueDepth);
  localparam logic [jsf_pkg::QueueCntW-1:0] CntOne  = jsf_pkg::QueueCntW'(1);

  jsf_pkg::item_t                   mem_r [jsf_pkg::QueueDepth];
  logic [jsf_pkg::QueuePtrW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [jsf_pkg::QueueCntW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CntFull);
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CntOne;
    else if (pop && !push) cnt_nxt = cnt_r - CntOne;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_q_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |-> !push)
    else $error("queue written while full");
`endif

endmodule

FILE: design/jsf_framer.sv
module jsf_framer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_length_limit,
  input  logic           q_empty,
  input  jsf_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte_out,
  output logic           out_is_start,
  output logic           out_is_end,
  output logic           out_keep,
  output logic           out_overflowed,
  output logic [15:0]    out_segment_length
);

  logic [15:0] limit_r;
  logic [15:0] cnt_r, cnt_nxt, cnt_inc;
  logic        lock_r, lock_nxt;
  logic        keep_nxt;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        start_r, end_r, keep_r, ovf_r;
  logic [15:0] len_r;

  assign cfg_ready = 1'b1;
  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign cnt_inc   = (cnt_r == jsf_pkg::CountMax) ? cnt_r : cnt_r + 16'd1;

  always_comb begin
    cnt_nxt  = cnt_r;
    lock_nxt = lock_r;
    keep_nxt = 1'b0;
    if (q_item.is_start) begin
      lock_nxt = 1'b0;
      cnt_nxt  = 16'd1;
      keep_nxt = 1'b1;
    end else if (q_item.is_end) begin
      if (lock_r) begin
        cnt_nxt = 16'd0;
      end else begin
        keep_nxt = 1'b1;
        cnt_nxt  = cnt_inc;
      end
    end else if (!lock_r) begin
      keep_nxt = 1'b1;
      cnt_nxt  = cnt_inc;
      lock_nxt = (cnt_inc >= limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= jsf_pkg::LengthLimitRst;
      cnt_r       <= 16'd0;
      lock_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) limit_r <= cfg_length_limit;
      if (q_pop) begin
        cnt_r       <= cnt_nxt;
        lock_r      <= lock_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r  <= q_item.data;
      start_r <= q_item.is_start;
      end_r   <= q_item.is_end;
      keep_r  <= keep_nxt;
      ovf_r   <= lock_nxt;
      len_r   <= cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_out       = byte_r;
  assign out_is_start       = start_r;
  assign out_is_end         = end_r;
  assign out_keep           = keep_r;
  assign out_overflowed     = ovf_r;
  assign out_segment_length = len_r;

`ifndef SYNTHESIS
  a_ovf_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_end && out_overflowed) |-> (out_segment_length == 16'd0))
    else $error("overflowed segment end carries a nonzero length");
  a_start_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_start) |-> (out_keep && !out_overflowed &&
                                     out_segment_length == 16'd1))
    else $error("segment start did not restart the count");
`endif

endmodule

FILE: tb/sv/json_segment_tag_checker.sv
module json_segment_tag_checker #(
  parameter int DEPTH_BITS = jsf_pkg::DepthBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_length_limit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte_out,
  input  logic        out_is_start,
  input  logic        out_is_end,
  input  logic        out_keep,
  input  logic        out_overflowed,
  input  logic [15:0] out_segment_length,
  output int          tags_outstanding,
  output int          tag_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  ChOpenCurly    = jsf_pkg::ChOpenCurly;
  localparam logic [7:0]  ChOpenSquare   = jsf_pkg::ChOpenSquare;
  localparam logic [7:0]  ChCloseCurly   = jsf_pkg::ChCloseCurly;
  localparam logic [7:0]  ChCloseSquare  = jsf_pkg::ChCloseSquare;
  localparam logic [7:0]  ChQuote        = jsf_pkg::ChQuote;
  localparam logic [7:0]  ChBackslash    = jsf_pkg::ChBackslash;
  localparam logic [15:0] CountMax       = jsf_pkg::CountMax;
  localparam logic [15:0] LengthLimitRst = jsf_pkg::LengthLimitRst;

  typedef enum logic [1:0] {TagNone, TagStart, TagEnd} seg_tag_t;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        is_start;
    logic        is_end;
    logic        keep;
    logic        overflowed;
    logic [15:0] seg_len;
  } tag_word_t;

  localparam logic [DEPTH_BITS-1:0] DepthTop = '1;

  logic [15:0]           limit_q;
  logic [7:0]            prev_q;
  logic                  in_str_q;
  logic [DEPTH_BITS-1:0] curly_q;
  logic [DEPTH_BITS-1:0] square_q;
  logic [15:0]           kept_q;
  logic                  lock_q;
  tag_word_t             expected_tags[$];

  function automatic void clear_nesting();
    prev_q   = '0;
    in_str_q = 1'b0;
    curly_q  = '0;
    square_q = '0;
  endfunction

  function automatic seg_tag_t classify(input logic [7:0] c);
    seg_tag_t tag;
    logic     underflow;
    tag       = TagNone;
    underflow = 1'b0;
    if (c == ChQuote && prev_q != ChBackslash) in_str_q = !in_str_q;
    if ((c == ChOpenCurly && prev_q == ChCloseCurly) ||
        (c == ChOpenSquare && prev_q == ChCloseSquare)) clear_nesting();
    if (!in_str_q) begin
      if ((c == ChOpenCurly || c == ChOpenSquare) && curly_q == 0 && square_q == 0)
        tag = TagStart;
      case (c)
        ChOpenCurly:   if (curly_q != DepthTop) curly_q = curly_q + 1'b1;
        ChOpenSquare:  if (square_q != DepthTop) square_q = square_q + 1'b1;
        ChCloseCurly:  if (curly_q == 0) underflow = 1'b1; else curly_q = curly_q - 1'b1;
        ChCloseSquare: if (square_q == 0) underflow = 1'b1; else square_q = square_q - 1'b1;
        default: ;
      endcase
      if (underflow) begin
        clear_nesting();
        tag = TagNone;
      end else if ((c == ChCloseCurly || c == ChCloseSquare) &&
                   curly_q == 0 && square_q == 0) begin
        tag = TagEnd;
      end
    end
    prev_q = c;
    return tag;
  endfunction

  function automatic tag_word_t predict_tags(input logic [7:0] c);
    tag_word_t w;
    seg_tag_t  tag;
    tag    = classify(c);
    w.keep = 1'b0;
    case (tag)
      TagStart: begin
        lock_q = 1'b0;
        kept_q = 16'd1;
        w.keep = 1'b1;
      end
      TagEnd: begin
        if (lock_q) begin
          kept_q = '0;
        end else begin
          w.keep = 1'b1;
          if (kept_q != CountMax) kept_q = kept_q + 1'b1;
        end
      end
      default: begin
        if (!lock_q) begin
          w.keep = 1'b1;
          if (kept_q != CountMax) kept_q = kept_q + 1'b1;
          if (kept_q >= limit_q) lock_q = 1'b1;
        end
      end
    endcase
    w.byte_val   = c;
    w.is_start   = (tag == TagStart);
    w.is_end     = (tag == TagEnd);
    w.overflowed = lock_q;
    w.seg_len    = kept_q;
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      tag_errors++;
    end
  endfunction

  always @(posedge clk) begin
    tag_word_t want;
    if (!rst_n) begin
      limit_q = LengthLimitRst;
      clear_nesting();
      kept_q = '0;
      lock_q = 1'b0;
      tag_errors = 0;
      expected_tags.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tags.size() == 0) begin
          $error("unexpected result word: byte_out %0h", out_byte_out);
          tag_errors++;
        end else begin
          want = expected_tags.pop_front();
          check_field("byte_out", 16'(want.byte_val), 16'(out_byte_out));
          check_field("is_start", 16'(want.is_start), 16'(out_is_start));
          check_field("is_end", 16'(want.is_end), 16'(out_is_end));
          check_field("keep", 16'(want.keep), 16'(out_keep));
          check_field("overflowed", 16'(want.overflowed), 16'(out_overflowed));
          check_field("segment_length", want.seg_len, out_segment_length);
        end
      end
      if (cfg_valid && cfg_ready) limit_q = cfg_length_limit;
      if (in_valid && in_ready) expected_tags.push_back(predict_tags(in_data_byte));
    end
    tags_outstanding = expected_tags.size();
  end

endmodule

FILE: tb/sv/json_segment_framer_unit_tb.sv
module json_segment_framer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  ChOpenCurly    = jsf_pkg::ChOpenCurly;
  localparam logic [7:0]  ChOpenSquare   = jsf_pkg::ChOpenSquare;
  localparam logic [7:0]  ChCloseCurly   = jsf_pkg::ChCloseCurly;
  localparam logic [7:0]  ChCloseSquare  = jsf_pkg::ChCloseSquare;
  localparam logic [7:0]  ChQuote        = jsf_pkg::ChQuote;
  localparam logic [7:0]  ChBackslash    = jsf_pkg::ChBackslash;
  localparam logic [15:0] LengthLimitRst = jsf_pkg::LengthLimitRst;

  // Receiver hold-off length, long enough to back up the result register and queue
  localparam int HoldCycles = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_length_limit = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_out;
  logic        out_is_start;
  logic        out_is_end;
  logic        out_keep;
  logic        out_overflowed;
  logic [15:0] out_segment_length;
  int          tags_outstanding;
  int          tag_errors;

  // Stimulus controls shared between the sender and the receiver
  logic        idle_on = 1'b1;
  logic        stall_burst_req = 1'b0;
  int          words_sent = 0;
  logic [7:0]  byte_plan[$];

  always #5 clk = ~clk;

  json_segment_framer_unit i_dut (.*);

  json_segment_tag_checker i_chk (.*);

  // Hard stop in case a word never comes back
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: decide ready at each falling edge; on request, hold off once for a
  // long stretch counted here so the block backs up and drops in_ready.
  initial begin
    logic stall_done;
    stall_done = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_burst_req && !stall_done) begin
        out_ready <= 1'b0;
        stall_done = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_ready <= !idle_on || ($urandom_range(99) >= 30);
      end
    end
  end

  // Offer one word, maybe after a short gap; return at the falling edge after
  // the handshake so the next word can follow with no bubble.
  task automatic send_word(input logic [7:0] b);
    if (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic flush_plan();
    while (byte_plan.size() != 0) send_word(byte_plan.pop_front());
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tags_outstanding != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_idle();
    cfg_valid        <= 1'b1;
    cfg_length_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Any byte that is not a bracket, a quote or a backslash
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChOpenCurly || b == ChOpenSquare || b == ChCloseCurly ||
           b == ChCloseSquare || b == ChQuote || b == ChBackslash);
    return b;
  endfunction

  // Quoted text: may hold brackets, escaped quotes and escaped backslashes.
  task automatic plan_string();
    logic [7:0] b;
    int         r;
    byte_plan.push_back(ChQuote);
    repeat ($urandom_range(0, 6)) begin
      r = $urandom_range(99);
      if (r < 15) begin
        byte_plan.push_back(ChBackslash);
        byte_plan.push_back(ChQuote);
      end else if (r < 25) begin
        // an escaped backslash shields the next byte too, so follow it with plain text
        byte_plan.push_back(ChBackslash);
        byte_plan.push_back(ChBackslash);
        byte_plan.push_back(plain_byte());
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == ChQuote || b == ChBackslash);
        byte_plan.push_back(b);
      end
    end
    byte_plan.push_back(ChQuote);
  endtask

  // One well-formed object or array with random nesting and content.
  task automatic plan_segment(input int max_bytes);
    logic [7:0] closers[$];
    int         n;
    int         r;
    n = 1;
    if ($urandom_range(1)) begin
      byte_plan.push_back(ChOpenCurly);
      closers.push_back(ChCloseCurly);
    end else begin
      byte_plan.push_back(ChOpenSquare);
      closers.push_back(ChCloseSquare);
    end
    while (closers.size() != 0 && n < max_bytes) begin
      r = $urandom_range(99);
      if (r < 20 && closers.size() < 6) begin
        if ($urandom_range(1)) begin
          byte_plan.push_back(ChOpenCurly);
          closers.push_back(ChCloseCurly);
        end else begin
          byte_plan.push_back(ChOpenSquare);
          closers.push_back(ChCloseSquare);
        end
        n++;
      end else if (r < 45) begin
        byte_plan.push_back(closers.pop_back());
        n++;
      end else if (r < 65) begin
        plan_string();
        n += 4;
      end else begin
        byte_plan.push_back(plain_byte());
        n++;
      end
    end
    while (closers.size() != 0) byte_plan.push_back(closers.pop_back());
  endtask

  // Mostly whole segments, back to back or with gaps of text; the rest raw noise,
  // truncated segments and stray closing brackets.
  task automatic run_random(input int count);
    int target;
    int r;
    target = words_sent + count;
    while (words_sent < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        plan_segment(($urandom_range(9) == 0) ? 80 : $urandom_range(2, 30));
        if ($urandom_range(1))
          repeat ($urandom_range(1, 3)) byte_plan.push_back(plain_byte());
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) byte_plan.push_back(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        plan_segment($urandom_range(3, 20));
        repeat ($urandom_range(1, 2))
          if (byte_plan.size() != 0) void'(byte_plan.pop_back());
      end else begin
        byte_plan.push_back($urandom_range(1) ? ChCloseCurly : ChCloseSquare);
      end
      flush_plan();
    end
  endtask

  initial begin
    // Hold reset, then release it on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme bytes, strings with escapes, underflow, "][" and "}{" restarts
    byte_plan = '{8'h00, 8'hFF,
                  ChOpenCurly, ChQuote, ChCloseCurly, ChBackslash, ChQuote, ChQuote,
                  ChCloseCurly,
                  ChCloseSquare, ChCloseCurly,
                  ChOpenCurly, ChCloseSquare,
                  ChOpenSquare, ChCloseSquare, ChOpenSquare, ChCloseSquare,
                  ChOpenCurly, ChCloseCurly, ChOpenCurly, ChCloseCurly,
                  8'h61};
    flush_plan();

    // Smallest limit: lock right after the start, deliver an empty segment
    write_limit(16'd1);
    byte_plan = '{8'h61, ChOpenCurly, 8'h61, 8'h62, ChCloseCurly, 8'h63, ChOpenSquare,
                  ChCloseSquare};
    flush_plan();

    // Zero limit: lock on the first plain byte
    write_limit(16'd0);
    byte_plan = '{8'h20, 8'h21, ChOpenSquare, 8'h22, ChCloseSquare};
    flush_plan();

    // Largest limit; drive each depth past its ceiling (a wrapped depth would tag a
    // fresh start), then restart with "}{" and "][" and close the new segment
    write_limit(16'hFFFF);
    repeat (258) byte_plan.push_back(ChOpenCurly);
    byte_plan.push_back(ChCloseCurly);
    byte_plan.push_back(ChOpenCurly);
    byte_plan.push_back(ChCloseCurly);
    repeat (258) byte_plan.push_back(ChOpenSquare);
    byte_plan.push_back(ChCloseSquare);
    byte_plan.push_back(ChOpenSquare);
    byte_plan.push_back(ChCloseSquare);
    flush_plan();

    // Random at the reset limit, with one long receiver hold-off in the middle
    write_limit(LengthLimitRst);
    run_random(60);
    stall_burst_req = 1'b1;
    run_random(25);
    wait_idle();
    run_random(75);

    // Short limits, no idling on either side for the whole stretch
    idle_on = 1'b0;
    write_limit(16'($urandom_range(4, 24)));
    run_random(130);

    // Very short limits so most segments overflow
    idle_on = 1'b1;
    write_limit(16'($urandom_range(1, 8)));
    run_random(130);

    // Largest limit again: no segment overflows
    write_limit(16'hFFFF);
    run_random(120);

    // Drain, then keep watching the result port for any stray word
    wait_idle();
    repeat (8) @(negedge clk);
    if (tag_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: json_segment_framer_unit.f
design/jsf_pkg.sv
design/jsf_parser.sv
design/jsf_queue.sv
design/jsf_framer.sv
design/json_segment_framer_unit.sv
tb/sv/json_segment_tag_checker.sv
tb/sv/json_segment_framer_unit_tb.sv
